[rtl/core/ppc_pkg.sv]
// Shared constants, accumulator record and status codes for the correlation block.
package ppc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int FRAC_BITS   = 30;

  localparam int FIELD_W = 16;
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int TOT_W   = 33;
  localparam int SQ_W    = 47;
  localparam int PR_W    = 48;
  localparam int CORR_W  = 32;
  localparam int STAT_W  = 3;

  localparam int DIV_BASE = 64 + FRAC_BITS;

  localparam logic [31:0] ONE    = 32'd1 << FRAC_BITS;
  localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0] NORM_LIM = 64'd1 << 60;

  localparam logic [STAT_W-1:0] ST_OK  = 3'd0;
  localparam logic [STAT_W-1:0] ST_X   = 3'd1;
  localparam logic [STAT_W-1:0] ST_Y   = 3'd2;
  localparam logic [STAT_W-1:0] ST_Z   = 3'd3;
  localparam logic [STAT_W-1:0] ST_DEN = 3'd4;

  typedef struct packed {
    logic        [CNT_W-1:0] count;
    logic signed [TOT_W-1:0] tx;
    logic signed [TOT_W-1:0] ty;
    logic signed [TOT_W-1:0] tz;
    logic        [SQ_W-1:0]  sxx;
    logic        [SQ_W-1:0]  syy;
    logic        [SQ_W-1:0]  szz;
    logic signed [PR_W-1:0]  pxy;
    logic signed [PR_W-1:0]  pxz;
    logic signed [PR_W-1:0]  pyz;
  } acc_t;

endpackage

[rtl/core/ppc_if.sv]
// Sample and result channel interfaces.
interface ppc_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppc_pkg::FIELD_W-1:0]  sample_x;
  logic signed [ppc_pkg::FIELD_W-1:0]  sample_y;
  logic signed [ppc_pkg::FIELD_W-1:0]  sample_z;
  logic                                last;
  modport source (output valid, sample_x, sample_y, sample_z, last, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, last, output ready);
endinterface

interface ppc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [ppc_pkg::CORR_W-1:0]  correlation;
  logic        [ppc_pkg::STAT_W-1:0]  status;
  modport source (output valid, correlation, status, input ready);
  modport sink (input valid, correlation, status, output ready);
endinterface

[rtl/core/ppc_queue.sv]
// Two-entry queue of finished accumulator records.
module ppc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  ppc_pkg::acc_t  push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output ppc_pkg::acc_t  pop_data,
  input  logic           pop_ready
);

  ppc_pkg::acc_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[rtl/core/ppc_front.sv]
// Front end: takes samples, forms products, accumulates, and hands off records on last.
module ppc_front (
  input  logic              clk,
  input  logic              rst,
  ppc_sample_if.sink        samples,
  output logic              push_valid,
  output ppc_pkg::acc_t     push_data,
  input  logic              push_ready
);

  localparam int SB = ppc_pkg::SAMPLE_BITS;

  logic                                s1_valid;
  logic                                s1_last;
  logic signed [ppc_pkg::FIELD_W-1:0]  x1;
  logic signed [ppc_pkg::FIELD_W-1:0]  y1;
  logic signed [ppc_pkg::FIELD_W-1:0]  z1;
  logic signed [31:0]                  mxx;
  logic signed [31:0]                  myy;
  logic signed [31:0]                  mzz;
  logic signed [31:0]                  mxy;
  logic signed [31:0]                  mxz;
  logic signed [31:0]                  myz;
  logic signed [ppc_pkg::FIELD_W-1:0]  xs;
  logic signed [ppc_pkg::FIELD_W-1:0]  ys;
  logic signed [ppc_pkg::FIELD_W-1:0]  zs;

  ppc_pkg::acc_t acc;
  ppc_pkg::acc_t acc_next;
  logic          advance;
  logic          room;

  // sign-extend from the sample width
  assign xs = ppc_pkg::FIELD_W'(signed'(samples.sample_x[SB-1:0]));
  assign ys = ppc_pkg::FIELD_W'(signed'(samples.sample_y[SB-1:0]));
  assign zs = ppc_pkg::FIELD_W'(signed'(samples.sample_z[SB-1:0]));

  assign advance       = !s1_valid || !s1_last || push_ready;
  assign samples.ready = advance;
  assign room          = (acc.count < ppc_pkg::CNT_W'(ppc_pkg::MAX_SAMPLES));

  always_comb begin
    acc_next = acc;
    if (room) begin
      acc_next.count = acc.count + ppc_pkg::CNT_W'(1);
      acc_next.tx  = acc.tx + ppc_pkg::TOT_W'(x1);
      acc_next.ty  = acc.ty + ppc_pkg::TOT_W'(y1);
      acc_next.tz  = acc.tz + ppc_pkg::TOT_W'(z1);
      acc_next.sxx = acc.sxx + ppc_pkg::SQ_W'(unsigned'(mxx));
      acc_next.syy = acc.syy + ppc_pkg::SQ_W'(unsigned'(myy));
      acc_next.szz = acc.szz + ppc_pkg::SQ_W'(unsigned'(mzz));
      acc_next.pxy = acc.pxy + ppc_pkg::PR_W'(mxy);
      acc_next.pxz = acc.pxz + ppc_pkg::PR_W'(mxz);
      acc_next.pyz = acc.pyz + ppc_pkg::PR_W'(myz);
    end
  end

  assign push_valid = s1_valid && s1_last;
  assign push_data  = acc_next;

  always_ff @(posedge clk) begin
    if (advance) begin
      x1  <= xs;
      y1  <= ys;
      z1  <= zs;
      mxx <= xs * xs;
      myy <= ys * ys;
      mzz <= zs * zs;
      mxy <= xs * ys;
      mxz <= xs * zs;
      myz <= ys * zs;
      s1_last <= samples.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
    end else if (advance) begin
      s1_valid <= samples.valid;
      if (s1_valid) begin
        acc <= s1_last ? '0 : acc_next;
      end
    end
  end

endmodule

[rtl/core/ppc_mul.sv]
// 64x64 product modulo 2^64 from three 32x32 partial products, formed one at a time.
module ppc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] product
);

  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] pp;
  logic [63:0] acc;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] opa;
  logic [31:0] opb;

  assign product = acc;

  always_comb begin
    case (cnt)
      2'd0: begin
        opa = ra[31:0];
        opb = rb[31:0];
      end
      2'd1: begin
        opa = ra[31:0];
        opb = rb[63:32];
      end
      default: begin
        opa = ra[63:32];
        opb = rb[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ra <= a;
      rb <= b;
    end
    if (busy) begin
      pp <= opa * opb;
      case (cnt)
        2'd0:    acc <= '0;
        2'd1:    acc <= pp;
        default: acc <= acc + {pp[31:0], 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/ppc_ratio.sv]
// Iterative num / sqrt(a*b) in Q1.FRAC: normalize, one root pass on both operands, restoring divide.
module ppc_ratio (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [63:0]                       num,
  input  logic [63:0]                       a,
  input  logic [63:0]                       b,
  output logic                              done,
  output logic signed [ppc_pkg::CORR_W-1:0] q_out
);

  typedef enum logic [2:0] {R_IDLE, R_NORM, R_SQRT, R_MULD, R_DCHK, R_DIV} rstate_t;

  rstate_t     state;
  logic        neg;
  logic [63:0] m;
  logic [63:0] va;
  logic [63:0] vb;
  logic [4:0]  ea;
  logic [4:0]  eb;
  logic [63:0] ra;
  logic [63:0] rb;
  logic [63:0] bitv;
  logic [63:0] d;
  logic [63:0] rem;
  logic [31:0] q;
  logic [7:0]  k;
  logic [7:0]  k_lim;

  logic        a_low;
  logic        b_low;
  logic [63:0] ta;
  logic [63:0] tb;
  logic [63:0] va_next;
  logic [63:0] vb_next;
  logic [63:0] ra_next;
  logic [63:0] rb_next;
  logic [63:0] rem_sh;
  logic [63:0] rem_next;
  logic [31:0] q_next;
  logic        take;

  assign a_low = (va < ppc_pkg::NORM_LIM) && (va != 64'd0);
  assign b_low = (vb < ppc_pkg::NORM_LIM) && (vb != 64'd0);

  // one step of the digit-by-digit root on both operands
  always_comb begin
    ta = ra + bitv;
    tb = rb + bitv;
    if (va >= ta) begin
      va_next = va - ta;
      ra_next = (ra >> 1) + bitv;
    end else begin
      va_next = va;
      ra_next = ra >> 1;
    end
    if (vb >= tb) begin
      vb_next = vb - tb;
      rb_next = (rb >> 1) + bitv;
    end else begin
      vb_next = vb;
      rb_next = rb >> 1;
    end
  end

  // one restoring divide step, with carry out of the remainder
  always_comb begin
    rem_sh = {rem[62:0], m[63]};
    take   = rem[63] || (rem_sh >= d);
    rem_next = take ? rem_sh - d : rem_sh;
    q_next   = {q[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            neg   <= num[63];
            m     <= num[63] ? (~num + 64'd1) : num;
            va    <= a;
            vb    <= b;
            ea    <= '0;
            eb    <= '0;
            state <= R_NORM;
          end
        end
        R_NORM: begin
          if (a_low) begin
            va <= va << 2;
            ea <= ea + 5'd1;
          end
          if (b_low) begin
            vb <= vb << 2;
            eb <= eb + 5'd1;
          end
          if (!a_low && !b_low) begin
            ra    <= '0;
            rb    <= '0;
            bitv  <= 64'd1 << 62;
            state <= R_SQRT;
          end
        end
        R_SQRT: begin
          va   <= va_next;
          vb   <= vb_next;
          ra   <= ra_next;
          rb   <= rb_next;
          bitv <= bitv >> 2;
          if (bitv == 64'd1) begin
            state <= R_MULD;
          end
        end
        R_MULD: begin
          d     <= ra[31:0] * rb[31:0];
          k_lim <= 8'(ppc_pkg::DIV_BASE) + 8'(ea) + 8'(eb);
          rem   <= '0;
          q     <= '0;
          k     <= '0;
          state <= R_DCHK;
        end
        R_DCHK: begin
          if (d == 64'd0) begin
            q_out <= '0;
            done  <= 1'b1;
            state <= R_IDLE;
          end else begin
            state <= R_DIV;
          end
        end
        R_DIV: begin
          rem <= rem_next;
          m   <= m << 1;
          k   <= k + 8'd1;
          if (q_next > ppc_pkg::ONE) begin
            q_out <= neg ? -signed'(ppc_pkg::ONE) : signed'(ppc_pkg::ONE);
            done  <= 1'b1;
            state <= R_IDLE;
          end else if (k == k_lim - 8'd1) begin
            q_out <= neg ? -signed'(q_next) : signed'(q_next);
            done  <= 1'b1;
            state <= R_IDLE;
          end else begin
            q <= q_next;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ppc_back.sv]
// Back end: spreads, status checks, ratio sequencing and the result register.
module ppc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           mode,
  input  logic           pop_valid,
  input  ppc_pkg::acc_t  pop_data,
  output logic           pop_ready,
  ppc_result_if.source   results
);

  typedef enum logic [3:0] {
    S_IDLE, S_SPREAD, S_SPWAIT, S_CHECK, S_RATIO, S_RWAIT,
    S_PMUL, S_PWAIT, S_PCHECK, S_OUT
  } state_t;

  state_t                             state;
  ppc_pkg::acc_t                      ent;
  logic [2:0]                         idx;
  logic                               half;
  logic [63:0]                        m1;
  logic [63:0]                        c [6];
  logic [1:0]                         rsel;
  logic [1:0]                         pidx;
  logic signed [ppc_pkg::CORR_W-1:0]  r [3];
  logic [63:0]                        pa;
  logic [63:0]                        pb;
  logic [63:0]                        pnum;
  logic signed [ppc_pkg::CORR_W-1:0]  res;
  logic [ppc_pkg::STAT_W-1:0]         st;
  logic                               out_valid;
  logic signed [ppc_pkg::CORR_W-1:0]  out_corr;
  logic [ppc_pkg::STAT_W-1:0]         out_stat;

  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;
  logic        rat_start;
  logic [63:0] rat_num;
  logic [63:0] rat_a;
  logic [63:0] rat_b;
  logic        rat_done;
  logic signed [ppc_pkg::CORR_W-1:0] rat_q;

  logic [63:0] n64;
  logic [63:0] tx64;
  logic [63:0] ty64;
  logic [63:0] tz64;

  assign n64  = 64'(ent.count);
  assign tx64 = 64'(ent.tx);
  assign ty64 = 64'(ent.ty);
  assign tz64 = 64'(ent.tz);

  assign pop_ready = (state == S_IDLE);
  assign mul_start = (state == S_SPREAD) || (state == S_PMUL);
  assign rat_start = (state == S_RATIO);

  assign results.valid       = out_valid;
  assign results.correlation = out_corr;
  assign results.status      = out_stat;

  always_comb begin
    mul_a = n64;
    mul_b = 64'(ent.sxx);
    if (state == S_PMUL || state == S_PWAIT) begin
      case (pidx)
        2'd0: begin
          mul_a = 64'(r[1]);
          mul_b = 64'(r[1]);
        end
        2'd1: begin
          mul_a = 64'(r[2]);
          mul_b = 64'(r[2]);
        end
        default: begin
          mul_a = 64'(r[1]);
          mul_b = 64'(r[2]);
        end
      endcase
    end else if (!half) begin
      case (idx)
        3'd0:    mul_b = 64'(ent.sxx);
        3'd1:    mul_b = 64'(ent.syy);
        3'd2:    mul_b = 64'(ent.szz);
        3'd3:    mul_b = 64'(ent.pxy);
        3'd4:    mul_b = 64'(ent.pxz);
        default: mul_b = 64'(ent.pyz);
      endcase
    end else begin
      case (idx)
        3'd0: begin
          mul_a = tx64;
          mul_b = tx64;
        end
        3'd1: begin
          mul_a = ty64;
          mul_b = ty64;
        end
        3'd2: begin
          mul_a = tz64;
          mul_b = tz64;
        end
        3'd3: begin
          mul_a = tx64;
          mul_b = ty64;
        end
        3'd4: begin
          mul_a = tx64;
          mul_b = tz64;
        end
        default: begin
          mul_a = ty64;
          mul_b = tz64;
        end
      endcase
    end
  end

  always_comb begin
    case (rsel)
      2'd0: begin
        rat_num = c[3];
        rat_a   = c[0];
        rat_b   = c[1];
      end
      2'd1: begin
        rat_num = c[4];
        rat_a   = c[0];
        rat_b   = c[2];
      end
      2'd2: begin
        rat_num = c[5];
        rat_a   = c[1];
        rat_b   = c[2];
      end
      default: begin
        rat_num = pnum;
        rat_a   = pa;
        rat_b   = pb;
      end
    endcase
  end

  ppc_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  ppc_ratio u_ratio (
    .clk   (clk),
    .rst   (rst),
    .start (rat_start),
    .num   (rat_num),
    .a     (rat_a),
    .b     (rat_b),
    .done  (rat_done),
    .q_out (rat_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the result after its transfer unless a new one loads this cycle
      if (out_valid && results.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            ent   <= pop_data;
            res   <= '0;
            st    <= ppc_pkg::ST_OK;
            idx   <= '0;
            half  <= 1'b0;
            rsel  <= '0;
            state <= S_SPREAD;
          end
        end
        S_SPREAD: state <= S_SPWAIT;
        S_SPWAIT: begin
          if (mul_done) begin
            if (!half) begin
              m1    <= mul_p;
              half  <= 1'b1;
              state <= S_SPREAD;
            end else begin
              c[idx] <= m1 - mul_p;
              half   <= 1'b0;
              if (idx == 3'd5) begin
                state <= S_CHECK;
              end else begin
                idx   <= idx + 3'd1;
                state <= S_SPREAD;
              end
            end
          end
        end
        S_CHECK: begin
          if (c[0] == 64'd0) begin
            st    <= ppc_pkg::ST_X;
            state <= S_OUT;
          end else if (c[1] == 64'd0) begin
            st    <= ppc_pkg::ST_Y;
            state <= S_OUT;
          end else if (mode && c[2] == 64'd0) begin
            st    <= ppc_pkg::ST_Z;
            state <= S_OUT;
          end else begin
            state <= S_RATIO;
          end
        end
        S_RATIO: state <= S_RWAIT;
        S_RWAIT: begin
          if (rat_done) begin
            if (!mode || rsel == 2'd3) begin
              res   <= rat_q;
              state <= S_OUT;
            end else begin
              r[rsel] <= rat_q;
              if (rsel == 2'd2) begin
                pidx  <= '0;
                state <= S_PMUL;
              end else begin
                rsel  <= rsel + 2'd1;
                state <= S_RATIO;
              end
            end
          end
        end
        S_PMUL: state <= S_PWAIT;
        S_PWAIT: begin
          if (mul_done) begin
            case (pidx)
              2'd0: begin
                pa    <= ppc_pkg::ONE_SQ - mul_p;
                pidx  <= 2'd1;
                state <= S_PMUL;
              end
              2'd1: begin
                pb    <= ppc_pkg::ONE_SQ - mul_p;
                pidx  <= 2'd2;
                state <= S_PMUL;
              end
              default: begin
                pnum  <= (64'(r[0]) << ppc_pkg::FRAC_BITS) - mul_p;
                state <= S_PCHECK;
              end
            endcase
          end
        end
        S_PCHECK: begin
          if (signed'(pa) <= 64'sd0 || signed'(pb) <= 64'sd0) begin
            st    <= ppc_pkg::ST_DEN;
            state <= S_OUT;
          end else begin
            rsel  <= 2'd3;
            state <= S_RATIO;
          end
        end
        S_OUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_corr  <= res;
            out_stat  <= st;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/pearson_partial_correlation_top.sv]
// Top level of the Pearson / first-order partial correlation block.
//
//   channel   | direction | payload                               | transfer when
//   ----------+-----------+---------------------------------------+----------------------
//   samples   | in        | sample_x, sample_y, sample_z, last    | valid && ready
//   results   | out       | correlation (Q1.30), status           | valid && ready
//   cfg       | in        | cfg_data = mode                       | cfg_write high
//
// The front end takes one sample per cycle; ready drops only while a vector end
// waits for room in the two-entry record queue. Each record then costs the back
// end its spread products plus one ratio pass (mode 0) or four (mode 1); a ratio
// pass is made up of the normalize loop, the 32-step root and the divide of up to
// 64+30+ea+eb steps.
// Reset (rst, synchronous) clears the accumulators, queue, sequencers and mode.
// A stalled result holds in the output register; the front keeps accepting until the record queue fills.
module pearson_partial_correlation_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_data,
  ppc_sample_if.sink    samples,
  ppc_result_if.source  results
);

  // mode register: 0 plain Pearson, 1 partial given z
  logic          mode;
  logic          push_valid;
  logic          push_ready;
  ppc_pkg::acc_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  ppc_pkg::acc_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  // accumulate samples, emit a record per vector
  ppc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  // hold finished records so the front and back stall independently
  ppc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // compute spreads, checks and ratios, then drive the result register
  ppc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .results   (results)
  );

endmodule
